// ===== rtl/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg : shared definitions for the go-to-point steering block
// Register indexes, fixed-point widths, reset values and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package gtp_pkg;

  // register indexes on the write port
  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_TARGET_X        = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_Y        = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_DISTANCE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_ANGLE      = 3'd3;
  localparam logic [IDX_W-1:0] REG_REACH_THRESHOLD = 3'd4;

  // widest register
  localparam int unsigned DATA_W = 17;

  // reset values
  localparam logic [15:0] RST_GAIN_DISTANCE   = 16'd256;
  localparam logic [11:0] RST_GAIN_ANGLE      = 12'd100;
  localparam logic [16:0] RST_REACH_THRESHOLD = 17'd10;

  // CORDIC datapath
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned TABLE_LEN         = 24;
  localparam int unsigned XW                = 28;   // 17 bit delta << 8, plus gain growth
  localparam logic [31:0] ACC_QUARTER       = 32'h4000_0000;
  localparam logic [31:0] ACC_THREE_QUARTER = 32'hC000_0000;
  localparam logic [31:0] ACC_ROUND         = 32'h0000_8000;

  // 1/K in Q16 and output limits
  localparam logic [15:0] INV_K_Q16 = 16'd39797;
  localparam logic [16:0] DIST_MAX  = 17'd131071;
  localparam logic [14:0] DC_MAX_Q8 = 15'd25600;

  // arctangent of 2^-i, 2^32 per full turn
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

// ===== rtl/go_to_point_p_controller.sv =====
// ----------------------------------------------------------------------------
// go_to_point_p_controller : proportional go-to-point steering
// Pose in, left/right motor orders, distance, heading error and a reached
// flag out, through an unrolled CORDIC vectoring pipeline.
// ----------------------------------------------------------------------------
// A request (start high, busy low) is taken on every clock; busy is always
// low. Its result appears on done, with all output fields, and is shown for
// one cycle only, since the receiver cannot hold it off. The result passes
// through the unrolled CORDIC, one register stage per iteration, plus seven
// stages for the delta, the quadrant turn, the 1/K scaling, the distance
// saturation, the gain products, the clamp and the final rounding. The user
// must write registers only while no request is in flight; the block itself
// does not enforce it.
module go_to_point_p_controller #(
  parameter int unsigned CORDIC_STAGES = gtp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request side
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            pos_x,
  input  logic signed [15:0]            pos_y,
  input  logic signed [15:0]            heading,
  // register write port
  input  logic                          wr_en,
  input  logic [gtp_pkg::IDX_W-1:0]     wr_index,
  input  logic [gtp_pkg::DATA_W-1:0]    wr_data,
  // result side
  output logic                          done,
  output logic signed [13:0]            left_cmd,
  output logic signed [13:0]            right_cmd,
  output logic                          reached,
  output logic [16:0]                   distance_error,
  output logic signed [15:0]            angle_error
);

  localparam int unsigned XW = gtp_pkg::XW;

  // configuration registers
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic [15:0]        gain_distance;
  logic [11:0]        gain_angle;
  logic [16:0]        reach_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x        <= '0;
      target_y        <= '0;
      gain_distance   <= gtp_pkg::RST_GAIN_DISTANCE;
      gain_angle      <= gtp_pkg::RST_GAIN_ANGLE;
      reach_threshold <= gtp_pkg::RST_REACH_THRESHOLD;
    end else if (wr_en) begin
      unique case (wr_index)
        gtp_pkg::REG_TARGET_X:        target_x        <= wr_data[15:0];
        gtp_pkg::REG_TARGET_Y:        target_y        <= wr_data[15:0];
        gtp_pkg::REG_GAIN_DISTANCE:   gain_distance   <= wr_data[15:0];
        gtp_pkg::REG_GAIN_ANGLE:      gain_angle      <= wr_data[11:0];
        gtp_pkg::REG_REACH_THRESHOLD: reach_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // never stalls
  assign busy = 1'b0;

  // stage 0: vector to target
  logic               s0_vld;
  logic signed [16:0] s0_dx;
  logic signed [16:0] s0_dy;
  logic [15:0]        s0_head;

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else     s0_vld <= start && !busy;
    s0_dx   <= {target_x[15], target_x} - {pos_x[15], pos_x};
    s0_dy   <= {target_y[15], target_y} - {pos_y[15], pos_y};
    s0_head <= heading;
  end

  // stage 1: scale by 2^8 and turn into the right half plane
  logic signed [XW-1:0] cx    [0:CORDIC_STAGES];
  logic signed [XW-1:0] cy    [0:CORDIC_STAGES];
  logic [31:0]          cacc  [0:CORDIC_STAGES];
  logic [15:0]          chead [0:CORDIC_STAGES];
  logic                 czero [0:CORDIC_STAGES];
  logic                 cvld  [0:CORDIC_STAGES];

  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;

  assign x_in = {{(XW-25){s0_dx[16]}}, s0_dx, 8'b0};
  assign y_in = {{(XW-25){s0_dy[16]}}, s0_dy, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) cvld[0] <= 1'b0;
    else     cvld[0] <= s0_vld;
    chead[0] <= s0_head;
    czero[0] <= (s0_dx == '0) && (s0_dy == '0);
    if (!x_in[XW-1]) begin
      cx[0]   <= x_in;
      cy[0]   <= y_in;
      cacc[0] <= '0;
    end else if (!y_in[XW-1]) begin
      cx[0]   <= y_in;
      cy[0]   <= -x_in;
      cacc[0] <= gtp_pkg::ACC_QUARTER;
    end else begin
      cx[0]   <= -y_in;
      cy[0]   <= x_in;
      cacc[0] <= gtp_pkg::ACC_THREE_QUARTER;
    end
  end

  // CORDIC vectoring, one iteration per stage
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = cx[k] >>> k;
    assign ys = cy[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) cvld[k+1] <= 1'b0;
      else     cvld[k+1] <= cvld[k];
      chead[k+1] <= chead[k];
      czero[k+1] <= czero[k];
      if (!cy[k][XW-1]) begin
        cx[k+1]   <= cx[k] + ys;
        cy[k+1]   <= cy[k] - xs;
        cacc[k+1] <= cacc[k] + gtp_pkg::ATAN_TAB[k];
      end else begin
        cx[k+1]   <= cx[k] - ys;
        cy[k+1]   <= cy[k] + xs;
        cacc[k+1] <= cacc[k] - gtp_pkg::ATAN_TAB[k];
      end
    end
  end

  // 1/K scaling product; bearing rounded to 16 bits and heading error
  logic [XW-2:0] x_pos;
  logic [31:0]   acc_rnd;
  logic [15:0]   bearing;

  assign x_pos   = cx[CORDIC_STAGES][XW-1] ? '0 : cx[CORDIC_STAGES][XW-2:0];
  assign acc_rnd = cacc[CORDIC_STAGES] + gtp_pkg::ACC_ROUND;
  assign bearing = czero[CORDIC_STAGES] ? 16'd0 : acc_rnd[31:16];

  logic               sm_vld;
  logic [XW+14:0]     sm_prod;
  logic signed [15:0] sm_aerr;

  always_ff @(posedge clk) begin
    if (rst) sm_vld <= 1'b0;
    else     sm_vld <= cvld[CORDIC_STAGES];
    sm_prod <= x_pos * gtp_pkg::INV_K_Q16;
    sm_aerr <= bearing - chead[CORDIC_STAGES];
  end

  // distance, saturated
  logic [XW-10:0] dist_raw;
  assign dist_raw = sm_prod[XW+14:24];

  logic               sa_vld;
  logic [16:0]        sa_dist;
  logic signed [15:0] sa_aerr;

  always_ff @(posedge clk) begin
    if (rst) sa_vld <= 1'b0;
    else     sa_vld <= sm_vld;
    sa_dist <= (dist_raw > (XW-9)'(gtp_pkg::DIST_MAX)) ? gtp_pkg::DIST_MAX
                                                       : dist_raw[16:0];
    sa_aerr <= sm_aerr;
  end

  // gain products and reach compare
  logic               sb_vld;
  logic [32:0]        sb_dprod;
  logic signed [28:0] sb_anum;
  logic [16:0]        sb_dist;
  logic signed [15:0] sb_aerr;
  logic               sb_reached;

  always_ff @(posedge clk) begin
    if (rst) sb_vld <= 1'b0;
    else     sb_vld <= sa_vld;
    sb_dprod   <= sa_dist * gain_distance;
    sb_anum    <= $signed({1'b0, gain_angle}) * sa_aerr;
    sb_dist    <= sa_dist;
    sb_aerr    <= sa_aerr;
    sb_reached <= sa_dist < reach_threshold;
  end

  // clamp distance command
  logic               sc_vld;
  logic [14:0]        sc_dcq8;
  logic signed [28:0] sc_anum;
  logic [16:0]        sc_dist;
  logic signed [15:0] sc_aerr;
  logic               sc_reached;

  always_ff @(posedge clk) begin
    if (rst) sc_vld <= 1'b0;
    else     sc_vld <= sb_vld;
    sc_dcq8    <= (sb_dprod > 33'(gtp_pkg::DC_MAX_Q8)) ? gtp_pkg::DC_MAX_Q8
                                                       : sb_dprod[14:0];
    sc_anum    <= sb_anum;
    sc_dist    <= sb_dist;
    sc_aerr    <= sb_aerr;
    sc_reached <= sb_reached;
  end

  // motor orders, divided by 2^15 truncating toward zero
  logic signed [29:0] dc_ext;
  logic signed [29:0] an_ext;
  logic signed [29:0] num_l;
  logic signed [29:0] num_r;
  logic signed [29:0] bias_l;
  logic signed [29:0] bias_r;

  assign dc_ext = $signed({8'b0, sc_dcq8, 7'b0});
  assign an_ext = {sc_anum[28], sc_anum};
  assign num_l  = dc_ext - an_ext;
  assign num_r  = dc_ext + an_ext;
  assign bias_l = num_l + (num_l[29] ? 30'sd32767 : 30'sd0);
  assign bias_r = num_r + (num_r[29] ? 30'sd32767 : 30'sd0);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= sc_vld;
    left_cmd       <= bias_l[28:15];
    right_cmd      <= bias_r[28:15];
    reached        <= sc_reached;
    distance_error <= sc_dist;
    angle_error    <= sc_aerr;
  end

endmodule

// ===== rtl/gtp_checker.sv =====
// ----------------------------------------------------------------------------
// gtp_checker : port-level checks for the go-to-point steering block
// Watches latency, reset flush, the stall-free request side and command symmetry.
// ----------------------------------------------------------------------------
module gtp_checker #(
  parameter int unsigned LATENCY = gtp_pkg::CORDIC_STAGES_DEF + 7
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [13:0] left_cmd,
  input logic signed [13:0] right_cmd,
  input logic [16:0]        distance_error,
  input logic signed [15:0] angle_error
);

  // the request side never stalls
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // a result always traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result straight after reset");

  // no heading error: both wheels get the same order
  a_straight: assert property (@(posedge clk) disable iff (rst)
      (done && angle_error == 16'sd0) |-> left_cmd == right_cmd)
    else $error("unequal orders with zero heading error");

  // no distance error: the wheels get opposite orders
  a_spin: assert property (@(posedge clk) disable iff (rst)
      (done && distance_error == 17'd0) |-> left_cmd == -right_cmd)
    else $error("orders not opposite at zero distance");

endmodule

bind go_to_point_p_controller gtp_checker #(
  .LATENCY (CORDIC_STAGES + 7)
) u_gtp_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .left_cmd       (left_cmd),
  .right_cmd      (right_cmd),
  .distance_error (distance_error),
  .angle_error    (angle_error)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb : self-checking bench for go_to_point_p_controller
// Feeds pose requests through the command port and predicts the results
// with a local fixed-point steering model: CORDIC magnitude and bearing,
// heading error wrap, gain products and clamps. A short table of directed
// poses, typed-in results on its on-target rows, runs on the reset settings.
// Random poses follow under several register settings, the extremes too.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAGES      = gtp_pkg::CORDIC_STAGES_DEF;
  localparam int          LATENCY     = int'(STAGES) + 7;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 11;
  localparam int          PHASE_POSES = 50;
  localparam int          ROWS        = 22;

  // indexes that decode to no register
  localparam logic [gtp_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [gtp_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // arctan(2^-i), 2^32 per full turn
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [13:0] lcmd;
    logic signed [13:0] rcmd;
    logic               reach;
    logic [16:0]        distance;
    logic signed [15:0] aerr;
  } steer_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] hd;
    logic               typed;
    steer_t             want;
  } pose_row_t;

  localparam steer_t NO_EXP = '0;

  // directed poses; typed-in results only for the on-target rows
  localparam pose_row_t POSE_TABLE [ROWS] = '{
    // robot on target, heading sweeps, half-turn error wraps negative
    '{16'sd0, 16'sd0, 16'sd0,       1'b1, '{14'sd0,   14'sd0,   1'b1, 17'd0, 16'sd0}},
    '{16'sd0, 16'sd0, -16'sd32768,  1'b1, '{14'sd100, -14'sd100, 1'b1, 17'd0, -16'sd32768}},
    '{16'sd0, 16'sd0, 16'sd16384,   1'b1, '{14'sd50,  -14'sd50, 1'b1, 17'd0, -16'sd16384}},
    '{16'sd0, 16'sd0, 16'sd32767,   1'b1, '{14'sd99,  -14'sd99, 1'b1, 17'd0, -16'sd32767}},
    '{16'sd0, 16'sd0, -16'sd16384,  1'b1, '{-14'sd50, 14'sd50,  1'b1, 17'd0, 16'sd16384}},
    // each axis and three of the four quadrants
    '{-16'sd100, 16'sd0, 16'sd0,    1'b0, NO_EXP},
    '{16'sd100, 16'sd0, 16'sd0,     1'b0, NO_EXP},
    '{16'sd0, -16'sd100, 16'sd0,    1'b0, NO_EXP},
    '{16'sd0, 16'sd100, 16'sd0,     1'b0, NO_EXP},
    '{16'sd100, 16'sd100, 16'sd0,   1'b0, NO_EXP},
    '{16'sd100, -16'sd100, 16'sd0,  1'b0, NO_EXP},
    '{-16'sd100, 16'sd100, 16'sd0,  1'b0, NO_EXP},
    // pose extremes
    '{-16'sd32768, -16'sd32768, 16'sd0,      1'b0, NO_EXP},
    '{16'sd32767, 16'sd32767, -16'sd32768,   1'b0, NO_EXP},
    '{-16'sd32768, 16'sd32767, 16'sd32767,   1'b0, NO_EXP},
    '{16'sd32767, -16'sd32768, 16'sd12345,   1'b0, NO_EXP},
    // around the reach threshold
    '{-16'sd5, 16'sd3, 16'sd0,      1'b0, NO_EXP},
    '{16'sd1, 16'sd0, -16'sd1,      1'b0, NO_EXP},
    '{-16'sd9, 16'sd0, 16'sd0,      1'b0, NO_EXP},
    '{-16'sd10, 16'sd0, 16'sd0,     1'b0, NO_EXP},
    '{-16'sd11, 16'sd0, 16'sd0,     1'b0, NO_EXP},
    // alternating bit patterns
    '{16'sd21845, -16'sd21846, -16'sd21846, 1'b0, NO_EXP}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic signed [15:0]            pos_x = '0;
  logic signed [15:0]            pos_y = '0;
  logic signed [15:0]            heading = '0;
  logic                          wr_en = 1'b0;
  logic [gtp_pkg::IDX_W-1:0]     wr_index = '0;
  logic [gtp_pkg::DATA_W-1:0]    wr_data = '0;
  logic                          busy;
  logic                          done;
  logic signed [13:0]            left_cmd;
  logic signed [13:0]            right_cmd;
  logic                          reached;
  logic [16:0]                   distance_error;
  logic signed [15:0]            angle_error;

  // local copy of the register file
  logic signed [15:0]       tgt_x = '0;
  logic signed [15:0]       tgt_y = '0;
  logic [15:0]              gain_dist = gtp_pkg::RST_GAIN_DISTANCE;
  logic [11:0]              gain_ang = gtp_pkg::RST_GAIN_ANGLE;
  logic [16:0]              reach_th = gtp_pkg::RST_REACH_THRESHOLD;

  steer_t                   pending_steer_q [$];
  bit                       gaps_on = 1'b1;
  int                       fail_count = 0;
  int                       poses_sent = 0;
  int                       results_seen = 0;
  int                       at_target = 0;
  int                       cycle_count = 0;

  go_to_point_p_controller #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .left_cmd(left_cmd), .right_cmd(right_cmd), .reached(reached),
    .distance_error(distance_error), .angle_error(angle_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // steering result for one pose under the current registers
  function automatic steer_t steer_predict(input logic signed [15:0] px,
                                           input logic signed [15:0] py,
                                           input logic signed [15:0] hd);
    longint      dx, dy, vx, vy, sx, sy, tmp, dmag, dcq8, anum, lft, rgt;
    logic [31:0] ang, rnd;
    logic [15:0] bearing, aerr;
    steer_t      res;
    dx = longint'(tgt_x) - longint'(px);
    dy = longint'(tgt_y) - longint'(py);
    vx = dx * 256;
    vy = dy * 256;
    ang = '0;
    // left half plane: turn a quarter first
    if (vx < 0) begin
      tmp = vx;
      if (vy >= 0) begin
        vx = vy;
        vy = -tmp;
        ang = 32'h4000_0000;
      end else begin
        vx = -vy;
        vy = tmp;
        ang = 32'hC000_0000;
      end
    end
    // vectoring iterations, shifts floor toward minus infinity
    if (dx != 0 || dy != 0) begin
      for (int i = 0; i < STAGES && i < 24; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx = vx + sy;
          vy = vy - sx;
          ang = ang + ARCTAN_STEP[i];
        end else begin
          vx = vx - sy;
          vy = vy + sx;
          ang = ang - ARCTAN_STEP[i];
        end
      end
    end
    if (vx < 0) vx = 0;
    dmag = (vx * 39797) >>> 24;
    if (dmag > 131071) dmag = 131071;
    rnd = ang + 32'h0000_8000;
    bearing = (dx == 0 && dy == 0) ? 16'h0000 : rnd[31:16];
    aerr = bearing - hd;
    dcq8 = dmag * longint'(gain_dist);
    if (dcq8 > 25600) dcq8 = 25600;
    anum = longint'(gain_ang) * longint'($signed(aerr));
    lft = (dcq8 * 128 - anum) / 32768;
    rgt = (dcq8 * 128 + anum) / 32768;
    res.lcmd = lft[13:0];
    res.rcmd = rgt[13:0];
    res.reach = (dmag < longint'(reach_th));
    res.distance = dmag[16:0];
    res.aerr = aerr;
    return res;
  endfunction

  // one register write; leaves wr_en high for a following write
  task automatic write_reg(input logic [gtp_pkg::IDX_W-1:0] idx,
                           input logic [16:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    case (idx)
      gtp_pkg::REG_TARGET_X:        tgt_x = value[15:0];
      gtp_pkg::REG_TARGET_Y:        tgt_y = value[15:0];
      gtp_pkg::REG_GAIN_DISTANCE:   gain_dist = value[15:0];
      gtp_pkg::REG_GAIN_ANGLE:      gain_ang = value[11:0];
      gtp_pkg::REG_REACH_THRESHOLD: reach_th = value;
      default: ;
    endcase
  endtask

  // full register set, unused upper data bits randomised, plus a stray index
  task automatic program_regs(input logic [15:0] tx, input logic [15:0] ty,
                              input logic [15:0] gd, input logic [11:0] ga,
                              input logic [16:0] th);
    logic [16:0] junk;
    junk = 17'($urandom);
    write_reg(gtp_pkg::REG_TARGET_X, {junk[16], tx});
    write_reg(gtp_pkg::REG_TARGET_Y, {junk[15], ty});
    write_reg(gtp_pkg::REG_GAIN_DISTANCE, {junk[14], gd});
    write_reg(gtp_pkg::REG_GAIN_ANGLE, {junk[13:9], ga});
    write_reg(gtp_pkg::REG_REACH_THRESHOLD, th);
    write_reg(gtp_pkg::IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
              17'($urandom));
    wr_en <= 1'b0;
  endtask

  // one pose request; returns in the step of the accepting edge
  task automatic send_pose(input logic signed [15:0] px, input logic signed [15:0] py,
                           input logic signed [15:0] hd, input logic typed,
                           input steer_t want);
    while (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      pos_x <= 16'($urandom);
      pos_y <= 16'($urandom);
      heading <= 16'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    heading <= hd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_steer_q.push_back(typed ? want : steer_predict(px, py, hd));
    poses_sent++;
  endtask

  // wait for every outstanding result, then a little margin
  task automatic settle();
    while (pending_steer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    steer_t want;
    if (!rst && done) begin
      results_seen++;
      if (reached) at_target++;
      if (pending_steer_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result l=%0d r=%0d reach=%0b d=%0d a=%0d",
                   left_cmd, right_cmd, reached, distance_error, angle_error);
      end else begin
        want = pending_steer_q.pop_front();
        if (left_cmd !== want.lcmd || right_cmd !== want.rcmd ||
            reached !== want.reach || distance_error !== want.distance ||
            angle_error !== want.aerr) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"ERROR: result %0d: exp l=%0d r=%0d reach=%0b d=%0d a=%0d, ",
                      "got l=%0d r=%0d reach=%0b d=%0d a=%0d"}, results_seen,
                     want.lcmd, want.rcmd, want.reach, want.distance, want.aerr,
                     left_cmd, right_cmd, reached, distance_error, angle_error);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_steer_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] px, py, hd;
    logic [15:0]        tx, ty, gd;
    logic [11:0]        ga;
    logic [16:0]        th;
    int                 mode;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed poses on the reset settings
    for (int k = 0; k < ROWS; k++)
      send_pose(POSE_TABLE[k].px, POSE_TABLE[k].py, POSE_TABLE[k].hd,
                POSE_TABLE[k].typed, POSE_TABLE[k].want);
    start <= 1'b0;
    settle();

    // random poses, one register setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(16'h7FFF, 16'h8000, 16'hFFFF, 12'hFFF, 17'd92682);
        1: program_regs(16'h8000, 16'h7FFF, 16'h0000, 12'h000, 17'd0);
        2: program_regs(16'h0000, 16'h0000, 16'h0001, 12'hFFF, 17'h1FFFF);
        3: program_regs(16'h0000, 16'h0000, gtp_pkg::RST_GAIN_DISTANCE,
                        gtp_pkg::RST_GAIN_ANGLE, gtp_pkg::RST_REACH_THRESHOLD);
        default: begin
          tx = 16'($urandom);
          ty = 16'($urandom);
          gd = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(600));
          ga = 12'($urandom);
          case ($urandom_range(2))
            0: th = 17'($urandom);
            1: th = 17'($urandom_range(300));
            default: th = 17'($urandom_range(92682));
          endcase
          program_regs(tx, ty, gd, ga, th);
        end
      endcase
      // one long stretch without gaps
      gaps_on = (ph != 5);
      repeat (PHASE_POSES) begin
        mode = int'($urandom_range(9));
        hd = 16'($urandom);
        if (mode <= 4) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else if (mode <= 7) begin
          px = tgt_x + 16'($signed($urandom_range(80)) - 40);
          py = tgt_y + 16'($signed($urandom_range(80)) - 40);
        end else if (mode == 8) begin
          px = tgt_x;
          py = tgt_y;
          if ($urandom_range(1)) hd = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
        end else if ($urandom_range(1)) begin
          px = tgt_x;
          py = 16'($urandom);
        end else begin
          px = 16'($urandom);
          py = tgt_y;
        end
        send_pose(px, py, hd, 1'b0, NO_EXP);
      end
      start <= 1'b0;
      settle();
    end

    // drain and report
    while (pending_steer_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Run covered %0d poses over %0d register settings, %0d cycles.",
             poses_sent, PHASES + 1, cycle_count);
    $display("%0d results checked, %0d flagged at target, %0d mismatches.",
             results_seen, at_target, fail_count);
    if (fail_count == 0 && pending_steer_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_steer_q.size() != 0)
        $display("ERROR: %0d results never arrived", pending_steer_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
